@@ rtl/input_event_remapper_top_assert.svh @@
// Assertion macros shared by the remapper queue and back end.
`ifndef INPUT_EVENT_REMAPPER_TOP_ASSERT_SVH
`define INPUT_EVENT_REMAPPER_TOP_ASSERT_SVH

`ifndef SYNTH
`define IEM_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("remapper assertion failed");
`define IEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("remapper assertion failed");
`else
`define IEM_ASSERT(label, clk, rst_n, ante, cons)
`define IEM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/iem_pkg.sv @@
// Shared types and constants of the input event remapper.
package iem_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int AXIS_COUNT    = 8;
    localparam int BUTTON_COUNT  = 32;
    localparam int Q_DEPTH       = 2;

    localparam int TE_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int IN_W     = 248;
    localparam int OUT_W    = 40;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 32;
    localparam int ECNT_W   = 6;

    localparam logic [15:0] TRIG_MAX = 16'hFFFF;
    localparam logic [7:0]  HAT_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        OP_APPLY = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        TK_AXIS    = 3'd0,
        TK_BUTTON  = 3'd1,
        TK_TRIGGER = 3'd2,
        TK_HAT     = 3'd3,
        TK_RSV4    = 3'd4,
        TK_RSV5    = 3'd5,
        TK_RSV6    = 3'd6,
        TK_RSV7    = 3'd7
    } t_tkind;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_PRESENT = 2'd0,
        CFG_ID      = 2'd1,
        CFG_VERSION = 2'd2,
        CFG_COUNT   = 2'd3
    } t_cfg_idx;

    // Classified command handed from front to back.
    typedef struct packed {
        t_opcode            op;
        logic               ok;       // table present and id/version match
        logic [CNT_W-1:0]   cnt;      // entries to scan
        logic               slot_ok;
        logic [TE_W-1:0]    slot;
        logic [31:0]        hash;
        logic [3:0]         etype;
        logic signed [31:0] value;
        logic signed [31:0] scale;
        logic signed [31:0] offset;
        t_tkind             tkind;
        logic [7:0]         tidx;
        logic [31:0]        etime;
    } t_cmd;

endpackage

@@ rtl/iem_front.sv @@
// Front end: configuration registers, input unpacking and classification.
module iem_front
    import iem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CFG_D_W-1:0]  i_cfg_data,
    input  logic [IN_W-1:0]     i_tdata,
    output t_cmd                o_cmd
);

    logic              r_present;
    logic [31:0]       r_bundle_id;
    logic [31:0]       r_bundle_ver;
    logic [ECNT_W-1:0] r_entry_cnt;

    logic [4:0]  slot;
    logic [31:0] req_id;
    logic [31:0] req_ver;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= 1'b0;
            r_bundle_id  <= '0;
            r_bundle_ver <= '0;
            r_entry_cnt  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRESENT: r_present    <= i_cfg_data[0];
                CFG_ID:      r_bundle_id  <= i_cfg_data;
                CFG_VERSION: r_bundle_ver <= i_cfg_data;
                CFG_COUNT:   r_entry_cnt  <= i_cfg_data[ECNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign slot    = i_tdata[6:2];
    assign req_id  = i_tdata[181:150];
    assign req_ver = i_tdata[213:182];

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = t_opcode'(i_tdata[1:0]);
        o_cmd.ok      = r_present && (r_bundle_id == req_id) && (r_bundle_ver == req_ver);
        o_cmd.cnt     = (32'(r_entry_cnt) < TABLE_ENTRIES) ? CNT_W'(r_entry_cnt)
                                                            : CNT_W'(TABLE_ENTRIES);
        o_cmd.slot_ok = (32'(slot) < TABLE_ENTRIES);
        o_cmd.slot    = TE_W'(slot);
        o_cmd.hash    = i_tdata[38:7];
        o_cmd.etype   = i_tdata[42:39];
        o_cmd.value   = i_tdata[74:43];
        o_cmd.scale   = i_tdata[106:75];
        o_cmd.offset  = i_tdata[138:107];
        o_cmd.tkind   = t_tkind'(i_tdata[141:139]);
        o_cmd.tidx    = i_tdata[149:142];
        o_cmd.etime   = i_tdata[245:214];
    end

endmodule

@@ rtl/iem_fifo.sv @@
// Short command queue between the front and back ends.
`include "input_event_remapper_top_assert.svh"
module iem_fifo
    import iem_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != QC_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `IEM_ASSERT(a_no_overflow, i_clk, i_rst_n, r_cnt == QC_W'(Q_DEPTH), !do_push)

endmodule

@@ rtl/iem_back.sv @@
// Back end: mapping table, scan pipeline, logical state and result register.
`include "input_event_remapper_top_assert.svh"
module iem_back
    import iem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_cmd             i_q_data,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [OUT_W-1:0] o_tdata
);

    localparam int AX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int BT_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    typedef struct packed {
        logic [31:0]        hash;
        logic [3:0]         kind;
        logic signed [31:0] scale;
        logic signed [31:0] offset;
        t_tkind             tkind;
        logic [7:0]         tidx;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_iss;
    logic             r_mapped;

    t_entry           r_tbl [TABLE_ENTRIES];
    t_entry           r_ent;
    logic             r_s1_vld;
    logic             r_s2_vld;
    logic [31:0]      r_prod;
    logic [31:0]      r_off;
    t_tkind           r_tk;
    logic [7:0]       r_ti;

    logic [31:0]       r_axis [AXIS_COUNT];
    logic [BUTTON_COUNT-1:0] r_btn;
    logic [15:0]       r_trig_l;
    logic [15:0]       r_trig_r;
    logic [7:0]        r_hat;
    logic [31:0]       r_last_time;

    logic              r_out_vld;
    logic              r_out_status;
    logic              r_out_mapped;
    logic [31:0]       r_out_rd;

    logic        match;
    logic [31:0] res;
    logic        hit;
    logic        load_out;
    logic [31:0] rd_val;

    function automatic logic [15:0] clamp16(input logic [31:0] v);
        if (v[31]) return '0;
        return (v > 32'(TRIG_MAX)) ? TRIG_MAX : v[15:0];
    endfunction

    function automatic logic [7:0] clamp8(input logic [31:0] v);
        if (v[31]) return '0;
        return (v > 32'(HAT_MAX)) ? HAT_MAX : v[7:0];
    endfunction

    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign load_out = (r_state == ST_DONE) && (!r_out_vld || i_tready);
    assign match    = r_s1_vld && (r_ent.hash == r_cmd.hash) && (r_ent.kind == r_cmd.etype);
    assign res      = r_prod + r_off;

    always_comb begin
        case (r_tk)
            TK_AXIS:    hit = (32'(r_ti) < AXIS_COUNT);
            TK_BUTTON:  hit = (32'(r_ti) < BUTTON_COUNT);
            TK_TRIGGER: hit = (r_ti == 8'd0) || (r_ti == 8'd1);
            TK_HAT:     hit = (r_ti == 8'd0);
            default:    hit = 1'b0;
        endcase
    end

    always_comb begin
        case (r_cmd.tkind)
            TK_AXIS:    rd_val = (32'(r_cmd.tidx) < AXIS_COUNT) ? r_axis[AX_W'(r_cmd.tidx)] : '0;
            TK_BUTTON:  rd_val = (32'(r_cmd.tidx) < BUTTON_COUNT)
                                 ? 32'(r_btn[BT_W'(r_cmd.tidx)]) : '0;
            TK_TRIGGER: rd_val = (r_cmd.tidx == 8'd0) ? 32'(r_trig_l)
                               : (r_cmd.tidx == 8'd1) ? 32'(r_trig_r) : '0;
            TK_HAT:     rd_val = (r_cmd.tidx == 8'd0) ? 32'(r_hat) : '0;
            default:    rd_val = '0;
        endcase
    end

    // Table memory: write on a popped entry write, read one entry per scan cycle.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_data.op == OP_WRITE) && i_q_data.slot_ok) begin
            r_tbl[i_q_data.slot] <= '{hash:   i_q_data.hash,
                                      kind:   i_q_data.etype,
                                      scale:  i_q_data.scale,
                                      offset: i_q_data.offset,
                                      tkind:  i_q_data.tkind,
                                      tidx:   i_q_data.tidx};
        end
        r_ent <= r_tbl[r_iss[TE_W-1:0]];
    end

    // Command latch, multiply stage payload and result payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        r_prod <= 32'(r_cmd.value * r_ent.scale);
        r_off  <= r_ent.offset;
        r_tk   <= r_ent.tkind;
        r_ti   <= r_ent.tidx;
        if (load_out) begin
            r_out_status <= (r_cmd.op == OP_APPLY) && !r_cmd.ok;
            r_out_mapped <= r_mapped;
            r_out_rd     <= (r_cmd.op == OP_READ) ? rd_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iss       <= '0;
            r_mapped    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_btn       <= '0;
            r_trig_l    <= '0;
            r_trig_r    <= '0;
            r_hat       <= '0;
            r_last_time <= '0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_axis[i] <= '0;
            end
        end else begin
            r_s1_vld <= (r_state == ST_SCAN);
            r_s2_vld <= match;

            // Apply stage: later entries overwrite earlier ones in table order.
            if (r_s2_vld && hit) begin
                r_mapped <= 1'b1;
                case (r_tk)
                    TK_AXIS:    r_axis[AX_W'(r_ti)] <= res;
                    TK_BUTTON:  r_btn[BT_W'(r_ti)]  <= (res != '0);
                    TK_TRIGGER: begin
                        if (r_ti == 8'd0) begin
                            r_trig_l <= clamp16(res);
                        end else begin
                            r_trig_r <= clamp16(res);
                        end
                    end
                    TK_HAT:     r_hat <= clamp8(res);
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_iss    <= '0;
                        r_mapped <= 1'b0;
                        if ((i_q_data.op == OP_APPLY) && i_q_data.ok) begin
                            r_last_time <= i_q_data.etime;
                        end
                        if ((i_q_data.op == OP_APPLY) && i_q_data.ok && (i_q_data.cnt != '0)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    r_iss <= r_iss + 1'b1;
                    if ((r_iss + 1'b1) == r_cmd.cnt) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!r_s1_vld && !r_s2_vld) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_tdata  = {(OUT_W - 34)'(0), r_out_rd, r_out_mapped, r_out_status};

    `IEM_ASSERT(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_iss < r_cmd.cnt)
    `IEM_ASSERT(a_pipe_quiet, i_clk, i_rst_n, r_state == ST_IDLE || r_state == ST_DONE, !r_s1_vld && !r_s2_vld)
    `IEM_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, load_out, r_out_vld && r_state == ST_IDLE)

endmodule

@@ rtl/input_event_remapper_top.sv @@
// Top level of the input event remapper.
//
// Usage:
//   Slave stream (i_s_axis_*) takes one command beat: apply an event, write a
//   mapping table entry, or read one logical element. Master stream
//   (o_m_axis_*) returns exactly one result beat per command, in order.
//   The config channel (i_cfg_*) writes table_present, bundle id, bundle
//   version and entry count; write it only while the block is idle.
// Operation:
//   An apply event walks the first min(entry_count, 32) table entries, one
//   entry per cycle through a read / multiply / apply pipeline. A write,
//   read or rejected event skips the scan and goes straight to the result.
//   The table scan sets the rate: one command is worked at a time by the
//   back end.
//   A two-deep command queue sits between the front end and the scan engine,
//   so input beats are taken while the engine or the output is busy.
// Reset and stall:
//   Reset clears the registers, logical state, queue and result register;
//   table entries stay undefined until written. When the receiver holds
//   i_m_axis_tready low the result beat holds, the engine waits in its done
//   state and the queue fills, after which o_s_axis_tready drops.
module input_event_remapper_top
    import iem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write channel.
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CFG_D_W-1:0]  i_cfg_data,
    // Command stream.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // From bit 0: opcode[1:0], entry_slot[6:2], key_hash[38:7],
    // element_type[42:39], event_value[74:43], entry_scale[106:75],
    // entry_offset[138:107], target_kind[141:139], target_index[149:142],
    // req_bundle_id[181:150], req_bundle_version[213:182],
    // event_time[245:214], zero pad[247:246]
    input  logic [IN_W-1:0]     i_s_axis_tdata,
    // Result stream.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // From bit 0: status[0], was_mapped[1], read_value[33:2], zero pad[39:34]
    output logic [OUT_W-1:0]    o_m_axis_tdata
);

    t_cmd cmd_in;
    t_cmd cmd_q;
    logic q_ready;
    logic q_valid;
    logic q_pop;

    // Classify each beat against the current table registers.
    iem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (i_s_axis_tdata),
        .o_cmd       (cmd_in)
    );

    // Accept a beat whenever the queue has room.
    assign o_s_axis_tready = q_ready;

    iem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .o_ready (q_ready),
        .i_data  (cmd_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (cmd_q)
    );

    // Execute commands and drive the result register.
    iem_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_data  (cmd_q),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata)
    );

endmodule

@@ sim/tb_input_event_remapper_top.sv @@
// Self-checking testbench of the input event remapper: command stream in, result stream out.
module tb_input_event_remapper_top;
    import iem_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 110;
    localparam int DIR_ROWS     = 25;
    localparam int PRINT_CAP    = 40;
    localparam int TAIL_CYCLES  = 50;

    // One command beat, unpacked from the stream layout.
    typedef struct packed {
        t_opcode            op;
        logic [4:0]         slot;
        logic [31:0]        hash;
        logic [3:0]         etype;
        logic signed [31:0] value;
        logic signed [31:0] scale;
        logic signed [31:0] offset;
        t_tkind             tkind;
        logic [7:0]         tidx;
        logic [31:0]        req_id;
        logic [31:0]        req_ver;
        logic [31:0]        etime;
    } remap_cmd_t;

    // One result beat.
    typedef struct packed {
        logic        status;
        logic        mapped;
        logic [31:0] rdval;
    } remap_res_t;

    // Directed stimulus row; typed rows carry their result inline.
    typedef struct packed {
        remap_cmd_t cmd;
        logic       typed;
        remap_res_t res;
    } dir_row_t;

    localparam remap_res_t RES_IDLE   = '{1'b0, 1'b0, 32'd0};
    localparam remap_res_t RES_REJECT = '{1'b1, 1'b0, 32'd0};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index;
    logic [CFG_D_W-1:0]  i_cfg_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_W-1:0]    o_m_axis_tdata;

    input_event_remapper_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ---------------------------------------------------------------------
    // Predictor state: registers, mapping table and logical controller state
    // ---------------------------------------------------------------------
    logic        cfg_present;
    logic [31:0] cfg_id;
    logic [31:0] cfg_ver;
    logic [5:0]  cfg_count;

    logic [31:0] tbl_hash   [TABLE_ENTRIES];
    logic [3:0]  tbl_etype  [TABLE_ENTRIES];
    logic [31:0] tbl_scale  [TABLE_ENTRIES];
    logic [31:0] tbl_offset [TABLE_ENTRIES];
    t_tkind      tbl_tkind  [TABLE_ENTRIES];
    logic [7:0]  tbl_tidx   [TABLE_ENTRIES];

    logic [31:0] axis_val [AXIS_COUNT];
    logic        btn_on   [BUTTON_COUNT];
    logic [15:0] trig_left;
    logic [15:0] trig_right;
    logic [7:0]  hat_pos;
    logic [31:0] last_time;

    remap_res_t  awaited_results[$];
    int          err_count;
    int          results_seen;
    int          cycle_count;
    bit          rx_calm;

    // Per-phase key pool: events and entries draw on it so that they meet.
    logic [31:0] key_hash_pool [4];
    logic [3:0]  key_type_pool [4];

    dir_row_t    dir_rows [DIR_ROWS];

    // Clamp a two's complement word into 0..hi.
    function automatic logic [31:0] clamp_level(input logic [31:0] v, input logic [31:0] hi);
        if (v[31])
            return 32'd0;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the predictor by one command and return the result it causes.
    function automatic remap_res_t remap_command(input remap_cmd_t c);
        remap_res_t  r;
        int          n;
        logic [31:0] mixed;
        logic [7:0]  ix;
        r = RES_IDLE;
        case (c.op)
            OP_APPLY: begin
                if (!cfg_present || cfg_id != c.req_id || cfg_ver != c.req_ver) begin
                    r.status = 1'b1;
                end else begin
                    last_time = c.etime;
                    n = (cfg_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_count);
                    // Walk in table order: a later match overwrites an earlier one.
                    for (int e = 0; e < n; e++) begin
                        if (tbl_hash[e] == c.hash && tbl_etype[e] == c.etype) begin
                            mixed = c.value * tbl_scale[e] + tbl_offset[e];
                            ix = tbl_tidx[e];
                            case (tbl_tkind[e])
                                TK_AXIS: begin
                                    if (ix < AXIS_COUNT) begin
                                        axis_val[ix] = mixed;
                                        r.mapped = 1'b1;
                                    end
                                end
                                TK_BUTTON: begin
                                    if (ix < BUTTON_COUNT) begin
                                        btn_on[ix] = (mixed != 32'd0);
                                        r.mapped = 1'b1;
                                    end
                                end
                                TK_TRIGGER: begin
                                    if (ix == 8'd0) begin
                                        trig_left = clamp_level(mixed, 32'(TRIG_MAX));
                                        r.mapped = 1'b1;
                                    end else if (ix == 8'd1) begin
                                        trig_right = clamp_level(mixed, 32'(TRIG_MAX));
                                        r.mapped = 1'b1;
                                    end
                                end
                                TK_HAT: begin
                                    if (ix == 8'd0) begin
                                        hat_pos = clamp_level(mixed, 32'(HAT_MAX));
                                        r.mapped = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            OP_WRITE: begin
                tbl_hash[c.slot]   = c.hash;
                tbl_etype[c.slot]  = c.etype;
                tbl_scale[c.slot]  = c.scale;
                tbl_offset[c.slot] = c.offset;
                tbl_tkind[c.slot]  = c.tkind;
                tbl_tidx[c.slot]   = c.tidx;
            end
            OP_READ: begin
                case (c.tkind)
                    TK_AXIS:    if (c.tidx < AXIS_COUNT) r.rdval = axis_val[c.tidx];
                    TK_BUTTON:  if (c.tidx < BUTTON_COUNT) r.rdval = {31'd0, btn_on[c.tidx]};
                    TK_TRIGGER: begin
                        if (c.tidx == 8'd0)
                            r.rdval = {16'd0, trig_left};
                        else if (c.tidx == 8'd1)
                            r.rdval = {16'd0, trig_right};
                    end
                    TK_HAT:     if (c.tidx == 8'd0) r.rdval = {24'd0, hat_pos};
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_cmd(input remap_cmd_t c);
        logic [IN_W-1:0] d;
        d = '0;
        d[1:0]     = c.op;
        d[6:2]     = c.slot;
        d[38:7]    = c.hash;
        d[42:39]   = c.etype;
        d[74:43]   = c.value;
        d[106:75]  = c.scale;
        d[138:107] = c.offset;
        d[141:139] = c.tkind;
        d[149:142] = c.tidx;
        d[181:150] = c.req_id;
        d[213:182] = c.req_ver;
        d[245:214] = c.etime;
        return d;
    endfunction

    // Gap length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Data word biased toward the clamp edges and small magnitudes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return 32'($urandom_range(0, 16)) - 32'd8;
            3:       return 32'($urandom_range(65530, 65540));
            4:       return 32'($urandom_range(250, 260));
            default: return 32'd1;
        endcase
    endfunction

    // Random command: mostly well-formed events against the loaded table,
    // table writes with pool keys and reads of real elements; the rest is
    // unmatched keys, broken id/version and the unused opcode.
    function automatic remap_cmd_t random_command(input bit force_write);
        remap_cmd_t c;
        int         pick;
        int         k;
        c.op      = t_opcode'($urandom_range(0, 3));
        c.slot    = 5'($urandom_range(0, 31));
        c.hash    = $urandom;
        c.etype   = 4'($urandom_range(0, 15));
        c.value   = $urandom;
        c.scale   = $urandom;
        c.offset  = $urandom;
        c.tkind   = t_tkind'($urandom_range(0, 7));
        c.tidx    = 8'($urandom_range(0, 255));
        c.req_id  = $urandom;
        c.req_ver = $urandom;
        c.etime   = $urandom;
        pick = force_write ? 50 : $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (pick < 45) begin
            c.op      = OP_APPLY;
            c.hash    = key_hash_pool[k];
            c.etype   = key_type_pool[k];
            c.req_id  = cfg_id;
            c.req_ver = cfg_ver;
            c.value   = pick_word();
        end else if (pick < 65) begin
            c.op = OP_WRITE;
            if ($urandom_range(0, 4) != 0) begin
                c.hash  = key_hash_pool[k];
                c.etype = key_type_pool[k];
            end
            // Land most entries inside the scanned window.
            if (cfg_count != 0 && $urandom_range(0, 2) != 0)
                c.slot = 5'($urandom_range(0, int'(cfg_count) - 1));
            c.tkind = ($urandom_range(0, 9) == 0) ? t_tkind'($urandom_range(4, 7))
                                                  : t_tkind'($urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0) begin
                case (c.tkind)
                    TK_AXIS:    c.tidx = 8'($urandom_range(0, 9));
                    TK_BUTTON:  c.tidx = 8'($urandom_range(0, 33));
                    TK_TRIGGER: c.tidx = 8'($urandom_range(0, 2));
                    default:    c.tidx = 8'($urandom_range(0, 1));
                endcase
            end
            c.scale  = pick_word();
            c.offset = ($urandom_range(0, 1) == 0) ? 32'd0 : pick_word();
        end else if (pick < 80) begin
            c.op    = OP_READ;
            c.tkind = t_tkind'($urandom_range(0, 4));
            if ($urandom_range(0, 5) != 0)
                c.tidx = 8'($urandom_range(0, 33));
        end else if (pick < 88) begin
            c.op      = OP_APPLY;
            c.req_id  = cfg_id;
            c.req_ver = cfg_ver;
        end else if (pick < 95) begin
            // Pool key but one bit off in the id or the version.
            c.op      = OP_APPLY;
            c.hash    = key_hash_pool[k];
            c.etype   = key_type_pool[k];
            c.req_id  = cfg_id;
            c.req_ver = cfg_ver;
            if ($urandom_range(0, 1) == 0)
                c.req_id[$urandom_range(0, 31)] ^= 1'b1;
            else
                c.req_ver[$urandom_range(0, 31)] ^= 1'b1;
        end else begin
            c.op = OP_NONE;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        if (err_count < PRINT_CAP)
            $display("mismatch on result %0d, %s: got %h, want %h",
                     results_seen, what, got, want);
        err_count++;
    endtask

    // Drive one command beat and hold it until taken; valid stays high on return.
    task automatic send_command(input remap_cmd_t c, input logic typed, input remap_res_t res);
        remap_res_t r;
        @(negedge i_clk);
        i_s_axis_tdata  = pack_cmd(c);
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = remap_command(c);
        awaited_results.push_back(typed ? res : r);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every awaited result is back, then let the engine settle.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PRESENT: cfg_present = data[0];
            CFG_ID:      cfg_id      = data;
            CFG_VERSION: cfg_ver     = data;
            CFG_COUNT:   cfg_count   = data[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_config(input logic present, input logic [31:0] id,
                               input logic [31:0] ver, input logic [5:0] count);
        drain_results();
        cfg_write(CFG_PRESENT, {31'd0, present});
        cfg_write(CFG_ID, id);
        cfg_write(CFG_VERSION, ver);
        cfg_write(CFG_COUNT, {26'd0, count});
    endtask

    task automatic run_rows(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_command(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
    endtask

    // ---------------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: drop tready for random stretches, or keep it high when calm
    // ---------------------------------------------------------------------
    initial begin
        int rx_hold;
        rx_hold = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_axis_tready = 1'b0;
            end else begin
                i_m_axis_tready = 1'b1;
                if (!rx_calm)
                    rx_hold = pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: compare each result beat against the oldest awaited one
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        remap_res_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected beat", o_m_axis_tdata, '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_m_axis_tdata[0] !== want.status)
                    report_mismatch("status", o_m_axis_tdata[0], want.status);
                if (o_m_axis_tdata[1] !== want.mapped)
                    report_mismatch("was_mapped", o_m_axis_tdata[1], want.mapped);
                if (o_m_axis_tdata[33:2] !== want.rdval)
                    report_mismatch("read_value", o_m_axis_tdata[33:2], want.rdval);
                if (o_m_axis_tdata[39:34] !== 6'd0)
                    report_mismatch("pad", o_m_axis_tdata[39:34], '0);
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        remap_cmd_t c;
        logic [5:0] count;
        logic       present;
        logic [31:0] id;
        logic [31:0] ver;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_PRESENT;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        rx_calm         = 1'b0;
        err_count       = 0;
        results_seen    = 0;

        // Predictor reset; table entries are filled below before any scan.
        cfg_present = 1'b0;
        cfg_id      = '0;
        cfg_ver     = '0;
        cfg_count   = '0;
        for (int i = 0; i < AXIS_COUNT; i++)
            axis_val[i] = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
            btn_on[i] = 1'b0;
        trig_left  = '0;
        trig_right = '0;
        hat_pos    = '0;
        last_time  = '0;

        // Directed rows. Typed results are the plain ones: reset values,
        // rejects, writes, ignored targets, empty scans.
        dir_rows[0]  = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_AXIS, 8'd0,
                          32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        dir_rows[1]  = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_TRIGGER, 8'd1,
                          32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        // Event with no table loaded.
        dir_rows[2]  = '{'{OP_APPLY, 5'd0, 32'd0, 4'd0, 32'sd7, 32'sd0, 32'sd0, TK_AXIS, 8'd0,
                          32'd0, 32'd0, 32'd5}, 1'b1, RES_REJECT};
        // Unused opcode with every field at its top.
        dir_rows[3]  = '{'{OP_NONE, 5'd31, 32'hFFFF_FFFF, 4'd15, -32'sd1, -32'sd1, -32'sd1,
                          TK_RSV7, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                        1'b1, RES_IDLE};
        dir_rows[4]  = '{'{OP_WRITE, 5'd0, 32'hFFFF_FFFF, 4'd15, 32'sd0, 32'sd1, 32'sd0,
                          TK_AXIS, 8'd7, 32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        dir_rows[5]  = '{'{OP_WRITE, 5'd1, 32'hFFFF_FFFF, 4'd15, 32'sd0, -32'sd1,
                          32'sh7FFF_FFFF, TK_TRIGGER, 8'd1, 32'd0, 32'd0, 32'd0},
                        1'b1, RES_IDLE};
        dir_rows[6]  = '{'{OP_WRITE, 5'd2, 32'd0, 4'd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          TK_HAT, 8'd0, 32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        dir_rows[7]  = '{'{OP_WRITE, 5'd3, 32'd0, 4'd0, 32'sd0, 32'sd1, 32'sd0, TK_BUTTON,
                          8'd31, 32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        // Reserved target kind: matched but ignored.
        dir_rows[8]  = '{'{OP_WRITE, 5'd4, 32'd0, 4'd0, 32'sd0, 32'sd1, 32'sd1, TK_RSV7,
                          8'd255, 32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        // Axis index past the last axis.
        dir_rows[9]  = '{'{OP_WRITE, 5'd5, 32'h1234_5678, 4'd3, 32'sd0, 32'sd1, 32'sd0, TK_AXIS,
                          8'd8, 32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        // Table loaded as id all ones, version zero, six entries.
        dir_rows[10] = '{'{OP_APPLY, 5'd0, 32'hFFFF_FFFF, 4'd15, 32'sd3, 32'sd0, 32'sd0, TK_AXIS,
                          8'd0, 32'hFFFF_FFFF, 32'd1, 32'd9}, 1'b1, RES_REJECT};
        dir_rows[11] = '{'{OP_APPLY, 5'd0, 32'hFFFF_FFFF, 4'd15, 32'sd3, 32'sd0, 32'sd0, TK_AXIS,
                          8'd0, 32'd0, 32'd0, 32'd9}, 1'b1, RES_REJECT};
        dir_rows[12] = '{'{OP_APPLY, 5'd0, 32'hFFFF_FFFF, 4'd15, 32'sh8000_0000, 32'sd0, 32'sd0,
                          TK_AXIS, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF}, 1'b0, RES_IDLE};
        dir_rows[13] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_AXIS, 8'd7,
                          32'd0, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        dir_rows[14] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_TRIGGER, 8'd1,
                          32'd0, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        dir_rows[15] = '{'{OP_APPLY, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_AXIS, 8'd0,
                          32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        dir_rows[16] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_BUTTON, 8'd31,
                          32'd0, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        // Hat clamps to its top, button 31 sets.
        dir_rows[17] = '{'{OP_APPLY, 5'd0, 32'd0, 4'd0, 32'sd2, 32'sd0, 32'sd0, TK_AXIS, 8'd0,
                          32'hFFFF_FFFF, 32'd0, 32'd77}, 1'b0, RES_IDLE};
        dir_rows[18] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_HAT, 8'd0,
                          32'd0, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        dir_rows[19] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_BUTTON, 8'd31,
                          32'd0, 32'd0, 32'd0}, 1'b0, RES_IDLE};
        // Only match points past the axes: accepted but unmapped.
        dir_rows[20] = '{'{OP_APPLY, 5'd0, 32'h1234_5678, 4'd3, 32'sd1, 32'sd0, 32'sd0, TK_AXIS,
                          8'd0, 32'hFFFF_FFFF, 32'd0, 32'd1}, 1'b1, RES_IDLE};
        dir_rows[21] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_RSV7, 8'd255,
                          32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        dir_rows[22] = '{'{OP_READ, 5'd0, 32'd0, 4'd0, 32'sd0, 32'sd0, 32'sd0, TK_AXIS, 8'd8,
                          32'd0, 32'd0, 32'd0}, 1'b1, RES_IDLE};
        // Entry count zero: nothing is scanned.
        dir_rows[23] = '{'{OP_APPLY, 5'd0, 32'd0, 4'd0, 32'sd5, 32'sd0, 32'sd0, TK_AXIS, 8'd0,
                          32'hFFFF_FFFF, 32'd0, 32'd2}, 1'b1, RES_IDLE};
        dir_rows[24] = '{'{OP_WRITE, 5'd31, 32'hFFFF_FFFF, 4'd15, 32'sd0, 32'sh8000_0000,
                          32'sh7FFF_FFFF, TK_BUTTON, 8'd0, 32'd0, 32'd0, 32'd0},
                        1'b1, RES_IDLE};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every slot while the count is still zero, so no scan ever
        // reaches an entry that was never written.
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            c = random_command(1'b1);
            c.slot = 5'(s);
            send_command(c, 1'b0, RES_IDLE);
        end

        run_rows(0, 9);
        load_config(1'b1, 32'hFFFF_FFFF, 32'd0, 6'd6);
        run_rows(10, 22);
        load_config(1'b1, 32'hFFFF_FFFF, 32'd0, 6'd0);
        run_rows(23, 24);

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            present = ($urandom_range(0, 9) != 0);
            id      = $urandom;
            ver     = $urandom;
            count   = 6'($urandom_range(0, TABLE_ENTRIES));
            case (p)
                0: begin
                    present = 1'b1;
                    id      = 32'hFFFF_FFFF;
                    ver     = 32'hFFFF_FFFF;
                    count   = 6'(TABLE_ENTRIES);
                end
                1: begin
                    present = 1'b1;
                    id      = '0;
                    ver     = '0;
                    count   = '0;
                end
                2: present = 1'b0;
                3: begin
                    present = 1'b1;
                    count   = 6'd1;
                end
                default: ;
            endcase
            load_config(present, id, ver, count);
            for (int k = 0; k < 4; k++) begin
                key_hash_pool[k] = $urandom;
                key_type_pool[k] = 4'($urandom_range(0, 15));
            end
            if (p == 0) begin
                key_hash_pool[0] = 32'hFFFF_FFFF;
                key_type_pool[0] = 4'd15;
                key_hash_pool[1] = 32'd0;
                key_type_pool[1] = 4'd0;
            end
            rx_calm = (p % 4 == 3);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Pause once per phase until the engine has emptied out.
                if (k == 55)
                    drain_results();
                c = random_command(k < 6);
                send_command(c, 1'b0, RES_IDLE);
                idle_sender(rx_calm ? 0 : pick_gap());
            end
        end

        rx_calm = 1'b0;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
